// ===== rtl/core/swrms_pkg.sv =====
// Shared widths, register indexes and helpers for the sliding-window RMS current meter.
`default_nettype none

package swrms_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int GAIN_W    = 24;
    localparam int OUT_W     = 16;
    localparam int RMS_W     = 18;
    localparam int FRAC_W    = 16;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int QUO_W     = SQ_W + FRAC_W;
    localparam int SREM_W    = RMS_W + 2;
    localparam int PROD_W    = RMS_W + GAIN_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = 2'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd320313;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]   t_gain;
    typedef logic [OUT_W-1:0]    t_out16;
    typedef logic [RMS_W-1:0]    t_rms;
    typedef logic [PROD_W-1:0]   t_prod;

    function automatic t_out16 sat16(input logic [RMS_W-1:0] v);
        if (v[RMS_W-1:OUT_W] != '0) begin
            return {OUT_W{1'b1}};
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sliding_window_rms_current_meter.sv =====
// Sliding-window RMS current meter: sample ring, running sum of squares, bit-serial divide and root.
//
// The oldest sample is read from the ring at the accepting edge. The states SQO, SQN and ACC
// then square the oldest sample, square the new one and update the sum of squares; the last
// of these also forms the sample gain product. The one-bit-per-cycle divider then scales the sum
// by 2^16 over the fill count, and the one-bit-per-cycle square root follows. The states MULV
// and MULI form the RMS gain products through the shared 18x24 multiplier. The FIN state loads
// the output register, and the block then returns to idle with the input stall low. All
// multiplications (both squares and the three gain products) use that one multiplier. The input
// stall stays high while an item is in work, and the output load waits while the previous result
// is still held in the output register. The ring clears through per-slot valid bits.
`default_nettype none

module sliding_window_rms_current_meter
    import swrms_pkg::*;
#(
    parameter int WINDOW = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [GAIN_W-1:0]     i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [SAMPLE_W-1:0]   i_adc_sample,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [OUT_W-1:0]     o_sample_millivolts,
    output logic [RMS_W-1:0]     o_rms_code,
    output logic [OUT_W-1:0]     o_rms_millivolts,
    output logic [OUT_W-1:0]     o_rms_milliamps
);

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int REM_W   = CNT_W + 1;
    localparam int SUM_W   = SQ_W + $clog2(WINDOW);
    localparam int HI_W    = SUM_W - SQ_W;
    localparam int ITER_W  = $clog2(QUO_W);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(QUO_W - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(RMS_W - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQO  = 4'd1;
    localparam logic [3:0] S_SQN  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_MULV = 4'd6;
    localparam logic [3:0] S_MULI = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [WINDOW-1:0] r_valid;
    t_gain             r_volt_gain;
    t_gain             r_cur_gain;
    logic              r_out_vld;

    t_sample           r_ring [WINDOW];
    t_sample           r_sample;
    t_sample           r_rd_data;
    logic              r_rd_vld;
    t_prod             r_prod;
    logic [REM_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_dvd;
    logic [SREM_W-1:0] r_srem;
    t_rms              r_root;
    t_out16            r_smv;
    t_out16            r_rmv;
    t_out16            r_o_smv;
    t_rms              r_o_rms;
    t_out16            r_o_rmv;
    t_out16            r_o_rma;

    logic              in_xfer;
    logic              out_free;
    logic              ring_we;
    t_sample           old_val;
    logic [RMS_W-1:0]  mul_a;
    t_gain             mul_b;
    t_prod             mul_p;
    logic [REM_W-1:0]  div_t;
    logic [REM_W-1:0]  div_d;
    logic              div_ge;
    logic [SREM_W-1:0] sq_t;
    logic [SREM_W-1:0] sq_trial;
    logic              sq_ge;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;
    assign ring_we  = (r_state == S_ACC);
    assign old_val  = r_rd_vld ? r_rd_data : '0;
    assign n_sum    = r_sum + r_prod[SUM_W-1:0];

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_out_vld;
    assign o_sample_millivolts = r_o_smv;
    assign o_rms_code          = r_o_rms;
    assign o_rms_millivolts    = r_o_rmv;
    assign o_rms_milliamps     = r_o_rma;

    always_comb begin
        case (r_state)
            S_SQO: begin
                mul_a = RMS_W'(old_val);
                mul_b = GAIN_W'(old_val);
            end
            S_SQN: begin
                mul_a = RMS_W'(r_sample);
                mul_b = GAIN_W'(r_sample);
            end
            S_ACC: begin
                mul_a = RMS_W'(r_sample);
                mul_b = r_volt_gain;
            end
            S_MULV: begin
                mul_a = r_root;
                mul_b = r_volt_gain;
            end
            S_MULI: begin
                mul_a = r_root;
                mul_b = r_cur_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_t  = {r_rem[CNT_W-1:0], r_dvd[QUO_W-1]};
    assign div_ge = (div_t >= {1'b0, r_cnt});
    assign div_d  = div_t - {1'b0, r_cnt};

    assign sq_t     = {r_srem[SREM_W-3:0], r_dvd[QUO_W-1:QUO_W-2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_SQO;
                end
            end
            S_SQO: n_state = S_SQN;
            S_SQN: n_state = S_ACC;
            S_ACC: begin
                n_state = S_DIV;
                n_iter  = '0;
            end
            S_DIV: begin
                if (r_iter == DIV_LAST) begin
                    n_state = S_SQRT;
                    n_iter  = '0;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_iter == SQRT_LAST) begin
                    n_state = S_MULV;
                    n_iter  = '0;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_MULV: n_state = S_MULI;
            S_MULI: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_slot      <= SLOT_W'(1);
            r_cnt       <= CNT_W'(1);
            r_sum       <= '0;
            r_valid     <= '0;
            r_volt_gain <= GAIN_RESET;
            r_cur_gain  <= GAIN_RESET;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            if (i_cfg_we && i_cfg_index == CFG_VOLT_GAIN) begin
                r_volt_gain <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_CURRENT_GAIN) begin
                r_cur_gain <= i_cfg_data;
            end
            if (r_state == S_SQN) begin
                r_sum <= r_sum - r_prod[SUM_W-1:0];
            end
            if (ring_we) begin
                r_sum           <= n_sum;
                r_valid[r_slot] <= 1'b1;
                r_slot          <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                if (r_cnt != CNT_FULL) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (r_state == S_FIN && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_slot] <= r_sample;
        end
        if (in_xfer) begin
            r_rd_data <= r_ring[r_slot];
            r_rd_vld  <= r_valid[r_slot];
            r_sample  <= i_adc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SQO, S_SQN, S_MULV: begin
                r_prod <= mul_p;
            end
            S_ACC: begin
                r_prod <= mul_p;
                r_rem  <= {{(REM_W - HI_W){1'b0}}, n_sum[SUM_W-1:SQ_W]};
                r_dvd  <= {n_sum[SQ_W-1:0], {FRAC_W{1'b0}}};
            end
            S_DIV: begin
                r_smv  <= sat16(r_prod[SAMPLE_W+GAIN_W-1:FRAC_W]);
                r_rem  <= div_ge ? div_d : div_t;
                r_dvd  <= {r_dvd[QUO_W-2:0], div_ge};
                r_srem <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_srem <= sq_ge ? (sq_t - sq_trial) : sq_t;
                r_root <= {r_root[RMS_W-2:0], sq_ge};
                r_dvd  <= {r_dvd[QUO_W-3:0], 2'b00};
            end
            S_MULI: begin
                r_prod <= mul_p;
                r_rmv  <= sat16(r_prod[PROD_W-1:GAIN_W]);
            end
            S_FIN: begin
                if (out_free) begin
                    r_o_smv <= r_smv;
                    r_o_rms <= r_root;
                    r_o_rmv <= r_rmv;
                    r_o_rma <= sat16(r_prod[PROD_W-1:GAIN_W]);
                end
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= CNT_FULL))
        else $error("fill count out of range");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("write slot out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_cnt}))
        else $error("divider remainder not below count");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (o_stall && !$stable(r_state)))
        else $error("input transfer did not start work");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_FIN))
        else $error("result appeared outside final step");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the sliding-window RMS current meter: directed probes, random runs.
`timescale 1ns / 1ps

module testbench;
    import swrms_pkg::*;

    localparam int WINDOW_LEN    = 64;
    localparam int SLOT_W        = $clog2(WINDOW_LEN);
    localparam int COUNT_W       = $clog2(WINDOW_LEN) + 1;
    localparam int SUM_W         = SQ_W + $clog2(WINDOW_LEN);
    localparam int PROBE_ROWS    = 20;
    localparam int PHASE_SAMPLES = 115;
    localparam int SETTLE_CYCLES = 70;
    localparam t_sample CODE_MAX = '1;
    localparam t_gain   GAIN_MAX = '1;
    localparam longint unsigned RMS_LIMIT = (64'd1 << RMS_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        t_out16 sample_mv;
        t_rms   code;
        t_out16 rms_mv;
        t_out16 rms_ma;
    } t_reading;

    typedef struct {
        t_sample  sample;
        bit       known;
        t_reading reading;
    } t_probe_row;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_VOLT_GAIN;
    logic [GAIN_W-1:0]    i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [SAMPLE_W-1:0]  i_adc_sample = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [OUT_W-1:0]     o_sample_millivolts;
    logic [RMS_W-1:0]     o_rms_code;
    logic [OUT_W-1:0]     o_rms_millivolts;
    logic [OUT_W-1:0]     o_rms_milliamps;

    sliding_window_rms_current_meter #(
        .WINDOW(WINDOW_LEN)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_adc_sample       (i_adc_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_sample_millivolts(o_sample_millivolts),
        .o_rms_code         (o_rms_code),
        .o_rms_millivolts   (o_rms_millivolts),
        .o_rms_milliamps    (o_rms_milliamps)
    );

    t_sample              window_ring [WINDOW_LEN];
    logic [SUM_W-1:0]     square_total;
    logic [SLOT_W-1:0]    oldest_slot;
    logic [COUNT_W-1:0]   samples_held;
    t_gain                volt_gain_q;
    t_gain                current_gain_q;

    t_reading pending_readings [$];
    t_reading due_reading;
    int       mismatch_count  = 0;
    int       readings_checked = 0;
    int       samples_sent    = 0;
    int       settings_used   = 1;
    int       stall_left      = 0;
    bit       stalls_on       = 1'b0;
    bit       gaps_on         = 1'b0;

    t_probe_row probe_rows [PROBE_ROWS] = '{
        '{10'd0,    1'b1, '{16'd0,    18'd0,      16'd0,    16'd0}},
        '{10'd0,    1'b1, '{16'd0,    18'd0,      16'd0,    16'd0}},
        '{10'd1023, 1'b1, '{16'd5000, 18'd130944, 16'd2500, 16'd2500}},
        '{10'd1,    1'b0, '0},
        '{10'd2,    1'b0, '0},
        '{10'd4,    1'b0, '0},
        '{10'd8,    1'b0, '0},
        '{10'd16,   1'b0, '0},
        '{10'd32,   1'b0, '0},
        '{10'd64,   1'b0, '0},
        '{10'd128,  1'b0, '0},
        '{10'd256,  1'b0, '0},
        '{10'd512,  1'b0, '0},
        '{10'd1023, 1'b0, '0},
        '{10'd0,    1'b0, '0},
        '{10'd682,  1'b0, '0},
        '{10'd341,  1'b0, '0},
        '{10'd1022, 1'b0, '0},
        '{10'd1023, 1'b0, '0},
        '{10'd0,    1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("testbench: errors");
        $finish;
    end

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 21; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_out16 clip16(input longint unsigned v);
        return (v > 64'd65535) ? '1 : t_out16'(v);
    endfunction

    function automatic t_reading meter_step(input t_sample s);
        t_reading        r;
        longint unsigned radicand;
        longint unsigned root;
        square_total = square_total - SUM_W'(window_ring[oldest_slot]) * window_ring[oldest_slot];
        window_ring[oldest_slot] = s;
        square_total = square_total + SUM_W'(s) * s;
        oldest_slot = (oldest_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : oldest_slot + 1'b1;
        if (samples_held < COUNT_W'(WINDOW_LEN)) begin
            samples_held = samples_held + 1'b1;
        end
        radicand = (64'(square_total) << FRAC_W) / 64'(samples_held);
        root = floor_root(radicand);
        if (root > RMS_LIMIT) begin
            root = RMS_LIMIT;
        end
        r.sample_mv = clip16((64'(s) * 64'(volt_gain_q)) >> 16);
        r.code      = t_rms'(root);
        r.rms_mv    = clip16((root * 64'(volt_gain_q)) >> 24);
        r.rms_ma    = clip16((root * 64'(current_gain_q)) >> 24);
        return r;
    endfunction

    task automatic report_field(input string label, input logic [RMS_W-1:0] want,
                                input logic [RMS_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected reading, expected none, got code %0d",
                         $time, o_rms_code);
            end else begin
                due_reading = pending_readings.pop_front();
                readings_checked++;
                report_field("sample_millivolts", RMS_W'(due_reading.sample_mv),
                             RMS_W'(o_sample_millivolts));
                report_field("rms_code", due_reading.code, o_rms_code);
                report_field("rms_millivolts", RMS_W'(due_reading.rms_mv),
                             RMS_W'(o_rms_millivolts));
                report_field("rms_milliamps", RMS_W'(due_reading.rms_ma),
                             RMS_W'(o_rms_milliamps));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!stalls_on) begin
            stall_left = 0;
        end else if (stall_left == 0 && $urandom_range(5) == 0) begin
            stall_left = $urandom_range(13, 1);
        end
        i_stall <= (stall_left != 0);
        if (stall_left != 0) begin
            stall_left--;
        end
    end

    task automatic transfer_sample(input t_sample s, input bit known, input t_reading typed);
        t_reading predicted;
        i_valid      <= 1'b1;
        i_adc_sample <= s;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = meter_step(s);
        pending_readings.push_back(known ? typed : predicted);
        samples_sent++;
        if (gaps_on && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain_readings();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input t_gain value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_VOLT_GAIN: begin
                volt_gain_q = value;
            end
            CFG_CURRENT_GAIN: begin
                current_gain_q = value;
            end
            default: begin
            end
        endcase
    endtask

    task automatic random_samples(input int count);
        int      done;
        int      len;
        int      mode;
        t_sample level;
        done = 0;
        while (done < count) begin
            mode = $urandom_range(9);
            if (mode < 5) begin
                len = $urandom_range(80, 64);
                case ($urandom_range(2))
                    0: level = '0;
                    1: level = CODE_MAX;
                    default: level = t_sample'($urandom_range(1023));
                endcase
                repeat (len) transfer_sample(level, 1'b0, '0);
            end else if (mode < 8) begin
                len = $urandom_range(30, 5);
                repeat (len) transfer_sample(t_sample'($urandom_range(1023)), 1'b0, '0);
            end else begin
                len = $urandom_range(80, 64);
                for (int k = 0; k < len; k++) begin
                    transfer_sample(k[0] ? CODE_MAX : t_sample'(0), 1'b0, '0);
                end
            end
            done += len;
        end
    endtask

    initial begin
        foreach (window_ring[k]) begin
            window_ring[k] = '0;
        end
        square_total   = '0;
        oldest_slot    = SLOT_W'(1);
        samples_held   = COUNT_W'(1);
        volt_gain_q    = GAIN_RESET;
        current_gain_q = GAIN_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        stalls_on = 1'b1;
        gaps_on   = 1'b1;

        foreach (probe_rows[r]) begin
            transfer_sample(probe_rows[r].sample, probe_rows[r].known, probe_rows[r].reading);
        end
        drain_readings();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_VOLT_GAIN, GAIN_MAX);
                    write_reg(CFG_CURRENT_GAIN, '0);
                end
                1: begin
                    write_reg(CFG_VOLT_GAIN, '0);
                    write_reg(CFG_CURRENT_GAIN, GAIN_MAX);
                end
                2: begin
                    write_reg(CFG_VOLT_GAIN, t_gain'($urandom));
                    write_reg(CFG_CURRENT_GAIN, t_gain'($urandom));
                    write_reg(CFG_SPARE_LO, t_gain'($urandom));
                    write_reg(CFG_SPARE_HI, GAIN_MAX);
                end
                3: begin
                    stalls_on = 1'b0;
                    write_reg(CFG_VOLT_GAIN, t_gain'(1));
                    write_reg(CFG_CURRENT_GAIN, t_gain'($urandom_range(2000000)));
                end
                4: begin
                    stalls_on = 1'b1;
                    gaps_on   = 1'b0;
                    write_reg(CFG_VOLT_GAIN, t_gain'($urandom_range(1000000)));
                    write_reg(CFG_CURRENT_GAIN, t_gain'($urandom));
                end
                default: begin
                    stalls_on = 1'b0;
                    gaps_on   = 1'b0;
                    write_reg(CFG_VOLT_GAIN, GAIN_RESET);
                    write_reg(CFG_CURRENT_GAIN, GAIN_RESET);
                end
            endcase
            settings_used++;
            random_samples(PHASE_SAMPLES);
            drain_readings();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            mismatch_count++;
            $display("%0t: readings never arrived, expected 0 left, got %0d",
                     $time, pending_readings.size());
        end

        $display("covered %0d samples over %0d gain settings, %0d readings checked",
                 samples_sent, settings_used, readings_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
